### rtl/core/mbe_pkg.sv
package mbe_pkg;

    // sequencer phases: idle, the phases of one iteration, and finish
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_UPDATE,
        ST_FINISH
    } mbe_state_t;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 64;
    localparam int LEFT_BITS = 16;
    localparam int EXT_BITS  = 48;

    localparam logic signed [WIDE_BITS-1:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_BITS-1:0] WORD_MIN = -64'sh0000_0000_8000_0000;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [WORD_BITS-1:0] r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX[WORD_BITS-1:0];
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN[WORD_BITS-1:0];
        end
        else
        begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/mbe_mul.sv
module mbe_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] product
);
    import mbe_pkg::*;

    logic signed [WIDE_BITS-1:0] prod_reg;
    logic signed [WIDE_BITS-1:0] prod_next;
    logic signed [WIDE_BITS-1:0] prod_shifted;

    assign prod_next = WIDE_BITS'(a) * WIDE_BITS'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // arithmetic shift rounds toward minus infinity
    assign prod_shifted = prod_reg >>> FRAC_BITS;
    assign product      = sat_word(prod_shifted);

endmodule

### rtl/core/mandelbrot_escape_iterator_core.sv
// Escape-time iterator for one pixel: repeats z = z*z + c in signed fixed point
// (FRAC_BITS fraction bits in 32 bits, saturating) until |z|^2 > 4 is seen on the
// old z or the budget runs out, then returns the budget left and the final z.
// Only the low COUNT_BITS bits of the budget are used, and a budget of zero
// counts as one. A single 32x32 multiplier is shared by the two squares and the
// cross product, so each iteration steps through the phases ST_SQ_RE, ST_SQ_IM,
// ST_CROSS and ST_UPDATE in turn. A pixel's result is held back in ST_FINISH only
// while the previous result is still waiting. in_ready is high only between
// pixels; a finished result waits in an output register, so the next pixel can
// start while it is still not taken.
module mandelbrot_escape_iterator_core #(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] c_real,
    input  logic signed [31:0] c_imag,
    input  logic signed [31:0] z_start_real,
    input  logic signed [31:0] z_start_imag,
    input  logic        [15:0] iteration_budget,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [15:0] iterations_left,
    output logic signed [31:0] z_final_real,
    output logic signed [31:0] z_final_imag
);
    import mbe_pkg::*;

    localparam logic signed [WORD_BITS:0] ESC_BOUND = 33'sd4 <<< FRAC_BITS;

    mbe_state_t state_reg;
    mbe_state_t state_next;

    logic                        load_item;
    logic                        step_update;
    logic                        load_out;

    logic signed [WORD_BITS-1:0] z_real_reg;
    logic signed [WORD_BITS-1:0] z_imag_reg;
    logic signed [WORD_BITS-1:0] c_real_reg;
    logic signed [WORD_BITS-1:0] c_imag_reg;
    logic signed [WORD_BITS-1:0] rr_reg;
    logic signed [WORD_BITS-1:0] ii_reg;
    logic        [COUNT_BITS-1:0] cnt_reg;
    logic        [COUNT_BITS-1:0] cnt_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic        [LEFT_BITS-1:0] left_out_reg;
    logic signed [WORD_BITS-1:0] zr_out_reg;
    logic signed [WORD_BITS-1:0] zi_out_reg;

    logic signed [WORD_BITS-1:0] mul_a;
    logic signed [WORD_BITS-1:0] mul_b;
    logic signed [WORD_BITS-1:0] mul_q;

    logic        [EXT_BITS-1:0]   budget_ext;
    logic        [COUNT_BITS-1:0] budget_cnt;
    logic        [EXT_BITS-1:0]   left_ext;
    logic signed [WORD_BITS:0]    mag;
    logic signed [WORD_BITS+1:0]  re_sum;
    logic signed [WORD_BITS+1:0]  im_sum;
    logic                         escaped;
    logic                         done;

    // shared multiplier: zr*zr, then zi*zi, then zr*zi
    assign mul_a = (state_reg == ST_SQ_IM) ? z_imag_reg : z_real_reg;
    assign mul_b = (state_reg == ST_SQ_RE) ? z_real_reg : z_imag_reg;

    mbe_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .a      (mul_a),
        .b      (mul_b),
        .product(mul_q)
    );

    assign budget_ext = EXT_BITS'(iteration_budget);
    assign budget_cnt = budget_ext[COUNT_BITS-1:0];

    // in the update phase the multiplier output holds the cross product
    assign mag     = (WORD_BITS+1)'(rr_reg) + (WORD_BITS+1)'(ii_reg);
    assign escaped = mag > ESC_BOUND;
    assign re_sum  = (WORD_BITS+2)'(rr_reg) - (WORD_BITS+2)'(ii_reg)
                   + (WORD_BITS+2)'(c_real_reg);
    assign im_sum  = ((WORD_BITS+2)'(mul_q) <<< 1) + (WORD_BITS+2)'(c_imag_reg);
    assign cnt_next = cnt_reg - COUNT_BITS'(1);
    assign done     = (cnt_next == '0) || escaped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_item   = 1'b0;
        step_update = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load_item  = 1'b1;
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE:  state_next = ST_SQ_IM;
            ST_SQ_IM:  state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                step_update = 1'b1;
                state_next  = done ? ST_FINISH : ST_SQ_RE;
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            z_real_reg <= z_start_real;
            z_imag_reg <= z_start_imag;
            c_real_reg <= c_real;
            c_imag_reg <= c_imag;
            cnt_reg    <= (budget_cnt == '0) ? COUNT_BITS'(1) : budget_cnt;
        end
        else if (step_update)
        begin
            z_real_reg <= sat_word(WIDE_BITS'(re_sum));
            z_imag_reg <= sat_word(WIDE_BITS'(im_sum));
            cnt_reg    <= cnt_next;
        end
        if (state_reg == ST_SQ_IM)
        begin
            rr_reg <= mul_q;
        end
        if (state_reg == ST_CROSS)
        begin
            ii_reg <= mul_q;
        end
    end

    assign left_ext = EXT_BITS'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_out_reg <= left_ext[LEFT_BITS-1:0];
            zr_out_reg   <= z_real_reg;
            zi_out_reg   <= z_imag_reg;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign iterations_left = left_out_reg;
    assign z_final_real    = zr_out_reg;
    assign z_final_imag    = zi_out_reg;

`ifndef SYNTHESIS
    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SQ_RE))
        else $error("request accepted but iteration did not start");

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_RE || state_reg == ST_SQ_IM ||
         state_reg == ST_CROSS || state_reg == ST_UPDATE) |-> (cnt_reg != '0))
        else $error("iteration running with empty budget");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (cnt_reg == $past(cnt_next)))
        else $error("budget not decremented by one per iteration");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result presented outside finish phase");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC_BITS = 24;
    localparam int FX_ONE = 1 << FRAC_BITS;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam longint ESCAPE_BOUND = 64'sd4 << FRAC_BITS;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic        [15:0] budget;
    } pixel_t;

    typedef struct packed {
        logic        [15:0] left;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
    } escape_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] z_start_real;
    logic signed [31:0] z_start_imag;
    logic        [15:0] iteration_budget;
    logic               out_valid;
    logic               out_ready;
    logic        [15:0] iterations_left;
    logic signed [31:0] z_final_real;
    logic signed [31:0] z_final_imag;

    escape_result_t expected_escapes[$];
    int             error_count;
    int             send_idle_pct;
    int             recv_idle_pct;

    mandelbrot_escape_iterator_core #(
        .FRAC_BITS(FRAC_BITS),
        .COUNT_BITS(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .c_real(c_real),
        .c_imag(c_imag),
        .z_start_real(z_start_real),
        .z_start_imag(z_start_imag),
        .iteration_budget(iteration_budget),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .iterations_left(iterations_left),
        .z_final_real(z_final_real),
        .z_final_imag(z_final_imag)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("mandelbrot_escape_iterator_core test failed");
        $finish;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI)
        begin
            return WORD_HI;
        end
        if (v < WORD_LO)
        begin
            return WORD_LO;
        end
        return v;
    endfunction

    // exact product, floor shift, then saturate
    function automatic longint fixed_mult(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp_word(p >>> FRAC_BITS);
    endfunction

    function automatic escape_result_t predict_escape(input pixel_t px);
        longint         cr;
        longint         ci;
        longint         zr;
        longint         zi;
        longint         rr;
        longint         ii;
        longint         ri;
        int             left;
        bit             escaped;
        escape_result_t r;
        cr = longint'($signed(px.cr));
        ci = longint'($signed(px.ci));
        zr = longint'($signed(px.zr));
        zi = longint'($signed(px.zi));
        left = int'(px.budget);
        if (left == 0)
        begin
            left = 1;
        end
        // escape test uses the squares of the old z, so the update still happens
        do
        begin
            rr = fixed_mult(zr, zr);
            ii = fixed_mult(zi, zi);
            ri = fixed_mult(zr, zi);
            escaped = (rr + ii) > ESCAPE_BOUND;
            zr = clamp_word(rr - ii + cr);
            zi = clamp_word(2 * ri + ci);
            left--;
        end
        while (left != 0 && !escaped);
        r.left = left[15:0];
        r.zr = zr[31:0];
        r.zi = zi[31:0];
        return r;
    endfunction

    function automatic pixel_t make_pixel(
        input logic signed [31:0] cr,
        input logic signed [31:0] ci,
        input logic signed [31:0] zr,
        input logic signed [31:0] zi,
        input logic        [15:0] budget
    );
        pixel_t px;
        px.cr = cr;
        px.ci = ci;
        px.zr = zr;
        px.zi = zi;
        px.budget = budget;
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
        begin
            $display("%0d ns: mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    // called right after a rising edge; leaves in_valid high after acceptance
    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        c_real <= px.cr;
        c_imag <= px.ci;
        z_start_real <= px.zr;
        z_start_imag <= px.zi;
        iteration_budget <= px.budget;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_escapes.push_back(predict_escape(px));
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        escape_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_escapes.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = expected_escapes.pop_front();
                if (iterations_left !== want.left)
                begin
                    report_mismatch($sformatf("iterations_left %0d, want %0d",
                        iterations_left, want.left));
                end
                if (z_final_real !== want.zr)
                begin
                    report_mismatch($sformatf("z_final_real %h, want %h",
                        z_final_real, want.zr));
                end
                if (z_final_imag !== want.zi)
                begin
                    report_mismatch($sformatf("z_final_imag %h, want %h",
                        z_final_imag, want.zi));
                end
            end
        end
    end

    task automatic test_budget_limits();
        send_pixel(make_pixel(FX_ONE / 4, 0, 0, 0, 16'd0));
        send_pixel(make_pixel(FX_ONE / 4, FX_ONE / 8, 0, 0, 16'd1));
        // never escapes: runs the full budget
        send_pixel(make_pixel(0, 0, 0, 0, 16'hFFFF));
        send_pixel(make_pixel(3 * FX_ONE, 0, 0, 0, 16'hFFFF));
        send_pixel(make_pixel(-3 * FX_ONE, FX_ONE, 0, 0, 16'h8000));
        send_pixel(make_pixel(0, 5 * FX_ONE, 0, 0, 16'h5555));
        send_pixel(make_pixel(0, -5 * FX_ONE, 0, 0, 16'hAAAA));
    endtask

    task automatic test_escape_timing();
        // escape seen on the last allowed update
        send_pixel(make_pixel(3 * FX_ONE, 0, 0, 0, 16'd2));
        // start already outside
        send_pixel(make_pixel(0, 0, 3 * FX_ONE, 0, 16'd10));
        send_pixel(make_pixel(0, 0, 0, -3 * FX_ONE, 16'd0));
        // |z|^2 exactly 4 is not an escape
        send_pixel(make_pixel(-2 * FX_ONE, 0, 2 * FX_ONE, 0, 16'd50));
        send_pixel(make_pixel(0, 0, 2 * FX_ONE + 1, 0, 16'd5));
        // negative products round toward minus infinity
        send_pixel(make_pixel(0, 0, -1, 1, 16'd4));
        send_pixel(make_pixel(-3 * FX_ONE / 4, FX_ONE / 10, 0, -FX_ONE / 2, 16'd20));
    endtask

    task automatic test_saturation();
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sh7FFF_FFFF;
        lo = 32'sh8000_0000;
        send_pixel(make_pixel(hi, hi, hi, hi, 16'd3));
        send_pixel(make_pixel(lo, lo, lo, lo, 16'd3));
        send_pixel(make_pixel(hi, lo, lo, hi, 16'd3));
        send_pixel(make_pixel(lo, hi, hi, lo, 16'd1));
        send_pixel(make_pixel(hi, 0, 0, 0, 16'hFFFF));
        send_pixel(make_pixel(0, lo, 0, 0, 16'hFFFE));
    endtask

    task automatic test_random_pixels(input int count);
        pixel_t px;
        int     kind;
        int     mag;
        repeat (count)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // around the set, small budgets so orbits run for a while
                px.cr = $urandom_range(0, 5 * FX_ONE / 2) - 2 * FX_ONE;
                px.ci = $urandom_range(0, 5 * FX_ONE / 2) - 5 * FX_ONE / 4;
                if ($urandom_range(1))
                begin
                    px.zr = 0;
                    px.zi = 0;
                end
                else
                begin
                    px.zr = $urandom_range(0, 3 * FX_ONE) - 3 * FX_ONE / 2;
                    px.zi = $urandom_range(0, 3 * FX_ONE) - 3 * FX_ONE / 2;
                end
                px.budget = ($urandom_range(99) < 5) ? 16'($urandom_range(0, 1023))
                                                     : 16'($urandom_range(0, 127));
            end
            else if (kind < 70)
            begin
                // far outside: escapes on the second test, so any budget is cheap
                mag = $urandom_range(5 * FX_ONE / 2, 100 * FX_ONE);
                px.cr = $urandom_range(1) ? mag : -mag;
                px.ci = $urandom_range(0, 2 * FX_ONE) - FX_ONE;
                px.zr = 0;
                px.zi = 0;
                px.budget = 16'($urandom_range(0, 65535));
            end
            else
            begin
                px.cr = $urandom;
                px.ci = $urandom;
                px.zr = $urandom;
                px.zi = $urandom;
                px.budget = 16'($urandom_range(0, 255));
            end
            send_pixel(px);
        end
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = 30;
        recv_idle_pct = 76;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        c_real <= '0;
        c_imag <= '0;
        z_start_real <= '0;
        z_start_imag <= '0;
        iteration_budget <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_budget_limits();
        test_escape_timing();
        test_saturation();
        test_random_pixels(340);
        send_idle_pct = 76;
        recv_idle_pct = 30;
        test_random_pixels(340);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(350);

        in_valid <= 1'b0;
        while (expected_escapes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("mandelbrot_escape_iterator_core test passed");
        end
        else
        begin
            $display("mandelbrot_escape_iterator_core test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/mbe_pkg.sv
rtl/core/mbe_mul.sv
rtl/core/mandelbrot_escape_iterator_core.sv
dv/tb_top.sv
